[hw/rtl/b64d_pkg.sv]
// Types, error codes and the character map shared by the Base64 stream decoder.
// No dependencies; compiled first.
`default_nettype none

package b64d_pkg;

  localparam logic [7:0] CHAR_PAD = 8'h3D;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_NON_ASCII,
    ERR_ILLEGAL,
    ERR_PREMATURE_END
  } b64d_err_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    b64d_err_t  error_code;
    logic       message_end;
    logic       last_of_run;
  } b64d_result_t;

  typedef struct packed {
    logic [1:0]                count;
    b64d_result_t [2:0]        res;
  } b64d_group_t;

  // Returns {in_alphabet, sextet}.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/b64d_ifs.sv]
// Valid/ready channel interfaces for the Base64 stream decoder.
// Uses nothing beyond plain logic; compiled after b64d_pkg.
`default_nettype none

interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last_symbol;

  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink (input valid, input symbol, input last_symbol, output ready);
endinterface

interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic [1:0] error_code;
  logic       message_end;
  logic       last_of_run;

  modport source (output valid, output data_byte, output byte_valid, output error_code,
                  output message_end, output last_of_run, input ready);
  modport sink (input valid, input data_byte, input byte_valid, input error_code,
                input message_end, input last_of_run, output ready);
endinterface

`default_nettype wire

[hw/rtl/b64d_decode.sv]
// Decoder state and the per-character decode into a group of up to three results.
// Depends on b64d_pkg.
`default_nettype none

module b64d_decode
  import b64d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  symbol,
  input  wire logic        last_symbol,
  output b64d_group_t      group
);

  logic [17:0] sextet_store, sextet_store_next;
  logic [1:0]  group_fill, group_fill_next;
  logic        pad_seen, pad_seen_next;
  b64d_err_t   latched_error, latched_error_next;

  logic [6:0]  sx;
  logic [23:0] full;
  b64d_err_t   err;
  logic [1:0]  n;

  always_comb begin
    sx = sextet_of(symbol);
    full = {sextet_store, sx[5:0]};
    sextet_store_next = sextet_store;
    group_fill_next = group_fill;
    pad_seen_next = pad_seen;
    latched_error_next = latched_error;
    err = ERR_NONE;
    n = 2'd0;
    group = '0;

    if (latched_error != ERR_NONE) begin
      if (last_symbol) begin
        group.res[0].error_code = latched_error;
        group.res[0].message_end = 1'b1;
        n = 2'd1;
        sextet_store_next = '0;
        group_fill_next = '0;
        pad_seen_next = 1'b0;
        latched_error_next = ERR_NONE;
      end
    end else begin
      if (symbol[7]) begin
        err = ERR_NON_ASCII;
      end else if (symbol == CHAR_PAD) begin
        pad_seen_next = 1'b1;
      end else if (!sx[6] || pad_seen) begin
        err = ERR_ILLEGAL;
      end else if (group_fill == 2'd3) begin
        group.res[0].data_byte = full[23:16];
        group.res[0].byte_valid = 1'b1;
        group.res[1].data_byte = full[15:8];
        group.res[1].byte_valid = 1'b1;
        group.res[2].data_byte = full[7:0];
        group.res[2].byte_valid = 1'b1;
        n = 2'd3;
        sextet_store_next = '0;
        group_fill_next = '0;
      end else begin
        sextet_store_next = {sextet_store[11:0], sx[5:0]};
        group_fill_next = group_fill + 2'd1;
      end

      if (err != ERR_NONE) begin
        group.res[0].error_code = err;
        group.res[0].message_end = last_symbol;
        n = 2'd1;
        if (last_symbol) begin
          sextet_store_next = '0;
          group_fill_next = '0;
          pad_seen_next = 1'b0;
        end else begin
          latched_error_next = err;
        end
      end else if (last_symbol) begin
        case (group_fill_next)
          2'd1: begin
            group.res[0].error_code = ERR_PREMATURE_END;
            group.res[0].message_end = 1'b1;
            n = 2'd1;
          end
          2'd2: begin
            group.res[0].data_byte = sextet_store_next[11:4];
            group.res[0].byte_valid = 1'b1;
            group.res[0].message_end = 1'b1;
            n = 2'd1;
          end
          2'd3: begin
            group.res[0].data_byte = sextet_store_next[17:10];
            group.res[0].byte_valid = 1'b1;
            group.res[1].data_byte = sextet_store_next[9:2];
            group.res[1].byte_valid = 1'b1;
            group.res[1].message_end = 1'b1;
            n = 2'd2;
          end
          default: begin
            if (n != 2'd0) begin
              group.res[2].message_end = 1'b1;
            end else begin
              group.res[0].message_end = 1'b1;
              n = 2'd1;
            end
          end
        endcase
        sextet_store_next = '0;
        group_fill_next = '0;
        pad_seen_next = 1'b0;
      end
    end

    group.res[0].last_of_run = (n == 2'd1);
    group.res[1].last_of_run = (n == 2'd2);
    group.res[2].last_of_run = (n == 2'd3);
    group.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_store <= '0;
      group_fill <= '0;
      pad_seen <= 1'b0;
      latched_error <= ERR_NONE;
    end else if (accept) begin
      sextet_store <= sextet_store_next;
      group_fill <= group_fill_next;
      pad_seen <= pad_seen_next;
      latched_error <= latched_error_next;
    end
  end

  // The last character of a message always leaves the decoder cleared.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last_symbol |=> group_fill == 2'd0 && !pad_seen && latched_error == ERR_NONE)
    else $error("state not cleared after the last character");

  // While an error is held, characters before the last one give no beat.
  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
    latched_error != ERR_NONE && !last_symbol |-> group.count == 2'd0)
    else $error("beat produced while dropping after an error");

  // A decoded byte never carries an error code.
  a_byte_no_err: assert property (@(posedge clk) disable iff (rst)
    group.res[0].byte_valid |-> group.res[0].error_code == ERR_NONE)
    else $error("byte beat carries an error");

endmodule

`default_nettype wire

[hw/rtl/b64d_out.sv]
// Result register for one group and the serializer that sends it one beat at a time.
// Depends on b64d_pkg and b64d_ifs.
`default_nettype none

module b64d_out
  import b64d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire b64d_group_t group,
  output logic             can_load,
  b64d_byte_if.source      byte_chan
);

  logic [1:0]         count;
  b64d_result_t [2:0] res;
  logic               pop;
  logic               fill;

  // A character that gives no result never touches the queue, so it is taken at any time.
  assign pop = (count != 2'd0) && byte_chan.ready;
  assign can_load = (count == 2'd0) || (count == 2'd1 && byte_chan.ready) ||
                    (group.count == 2'd0);
  assign fill = load && (group.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fill) begin
      count <= group.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fill) begin
      res <= group.res;
    end else if (pop) begin
      res[0] <= res[1];
      res[1] <= res[2];
    end
  end

  assign byte_chan.valid = (count != 2'd0);
  assign byte_chan.data_byte = res[0].data_byte;
  assign byte_chan.byte_valid = res[0].byte_valid;
  assign byte_chan.error_code = 2'(res[0].error_code);
  assign byte_chan.message_end = res[0].message_end;
  assign byte_chan.last_of_run = res[0].last_of_run;

  // The head beat closes its run exactly when it is the only one left.
  a_run_tail: assert property (@(posedge clk) disable iff (rst)
    count != 2'd0 |-> res[0].last_of_run == (count == 2'd1))
    else $error("last_of_run out of step with the beat count");

  // A taken beat of a longer run advances the queue by one.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    count > 2'd1 && pop |=> count == $past(count) - 2'd1)
    else $error("run did not advance by one beat");

  // The end of a message is also the end of a run.
  a_end_in_tail: assert property (@(posedge clk) disable iff (rst)
    count != 2'd0 && res[0].message_end |-> res[0].last_of_run)
    else $error("message end inside a run");

endmodule

`default_nettype wire

[hw/rtl/base64_stream_decoder.sv]
// Top level of the Base64 stream decoder: character channel in, byte channel out.
// Depends on b64d_pkg, b64d_ifs, b64d_decode and b64d_out.
//
// char_chan carries one character per beat, with last_symbol marking the final
// character of a message. byte_chan carries one result per beat: a decoded byte,
// an error report or an end marker, with message_end on the final beat of a
// message and last_of_run on the final beat caused by one character.
// A character is decoded in the cycle it is accepted and its results appear on
// byte_chan from the next cycle. A character that gives no result is accepted
// in any cycle, even while earlier beats are still queued. A character that
// gives results is accepted once the queue is empty or its last beat is taken
// in the same cycle. The three bytes of a full group drain while the next three
// characters come in, so with a ready receiver the block takes one character
// every cycle unless a character with results meets two or more queued beats.
// Reset clears the held sextets, the fill count, the padding flag, the held
// error and the output queue; the block is ready in the first cycle after it.
// When the receiver stalls, the pending results wait in the output register and
// char_chan.ready drops for a character that gives results until the last
// waiting beat is taken.
`default_nettype none

module base64_stream_decoder
  import b64d_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  b64d_char_if.sink   char_chan,
  b64d_byte_if.source byte_chan
);

  b64d_group_t group;
  logic        can_load;
  logic        accept;

  assign char_chan.ready = can_load;
  assign accept = char_chan.valid && can_load;

  b64d_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .symbol      (char_chan.symbol),
    .last_symbol (char_chan.last_symbol),
    .group       (group)
  );

  b64d_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .group     (group),
    .can_load  (can_load),
    .byte_chan (byte_chan)
  );

endmodule

`default_nettype wire

[tb/base64_stream_decoder_tb.sv]
// Self-checking testbench for base64_stream_decoder: a directed table and random messages.
// Results are predicted per character or given by the directed table, and checked beat by beat on the byte channel.
// Depends on b64d_pkg, b64d_ifs and the decoder RTL.

module base64_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import b64d_pkg::*;

  typedef enum logic [1:0] {
    ROW_PREDICTED,
    ROW_NO_RESULT,
    ROW_ONE_RESULT
  } row_check_t;

  typedef struct packed {
    logic [7:0]   sym;
    logic         lst;
    row_check_t   check;
    b64d_result_t typed_res;
  } stim_row_t;

  logic clk;
  logic rst;

  b64d_char_if char_chan ();
  b64d_byte_if byte_chan ();

  base64_stream_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .char_chan(char_chan),
    .byte_chan(byte_chan)
  );

  string b64_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [17:0]  sextet_acc;
  logic [1:0]   sextet_cnt;
  logic         pad_flag;
  b64d_err_t    sticky_err;

  b64d_result_t expected_beats[$];
  stim_row_t    directed_rows[$];

  int src_idle_pct;
  int sink_stall_pct;
  int hold_request;
  int mismatches;
  int chars_sent;
  int messages_sent;
  int beats_checked;
  int bytes_seen;
  int errors_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic b64d_result_t mk_res(input logic [7:0] b, input logic v, input b64d_err_t e,
                                          input logic me, input logic lr);
    b64d_result_t r;
    r.data_byte   = b;
    r.byte_valid  = v;
    r.error_code  = e;
    r.message_end = me;
    r.last_of_run = lr;
    return r;
  endfunction

  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (b64_chars[i] == c) return {1'b1, 6'(i)};
    end
    return 7'd0;
  endfunction

  function automatic void clear_decoder();
    sextet_acc = '0;
    sextet_cnt = '0;
    pad_flag   = 1'b0;
    sticky_err = ERR_NONE;
  endfunction

  function automatic b64d_group_t predict_decode(input logic [7:0] sym, input logic lst);
    b64d_group_t g;
    b64d_err_t   err;
    logic [6:0]  sx;
    logic [23:0] grp;
    int          n;
    g   = '0;
    n   = 0;
    err = ERR_NONE;
    if (sticky_err != ERR_NONE) begin
      if (lst) begin
        g.res[n] = mk_res(8'h00, 1'b0, sticky_err, 1'b1, 1'b0);
        n++;
        clear_decoder();
      end
    end else begin
      if (sym[7]) begin
        err = ERR_NON_ASCII;
      end else if (sym == CHAR_PAD) begin
        pad_flag = 1'b1;
      end else begin
        sx = char_sextet(sym);
        if (!sx[6] || pad_flag) begin
          err = ERR_ILLEGAL;
        end else if (sextet_cnt == 2'd3) begin
          grp = {sextet_acc, sx[5:0]};
          g.res[0] = mk_res(grp[23:16], 1'b1, ERR_NONE, 1'b0, 1'b0);
          g.res[1] = mk_res(grp[15:8], 1'b1, ERR_NONE, 1'b0, 1'b0);
          g.res[2] = mk_res(grp[7:0], 1'b1, ERR_NONE, 1'b0, 1'b0);
          n = 3;
          sextet_acc = '0;
          sextet_cnt = '0;
        end else begin
          sextet_acc = {sextet_acc[11:0], sx[5:0]};
          sextet_cnt = sextet_cnt + 2'd1;
        end
      end
      if (err != ERR_NONE) begin
        g.res[n] = mk_res(8'h00, 1'b0, err, lst, 1'b0);
        n++;
        if (lst) clear_decoder();
        else sticky_err = err;
      end else if (lst) begin
        case (sextet_cnt)
          2'd1: begin
            g.res[n] = mk_res(8'h00, 1'b0, ERR_PREMATURE_END, 1'b1, 1'b0);
            n++;
          end
          2'd2: begin
            g.res[n] = mk_res(sextet_acc[11:4], 1'b1, ERR_NONE, 1'b1, 1'b0);
            n++;
          end
          2'd3: begin
            grp = {sextet_acc, 6'd0};
            g.res[0] = mk_res(grp[23:16], 1'b1, ERR_NONE, 1'b0, 1'b0);
            g.res[1] = mk_res(grp[15:8], 1'b1, ERR_NONE, 1'b1, 1'b0);
            n = 2;
          end
          default: begin
            if (n > 0) begin
              g.res[n-1].message_end = 1'b1;
            end else begin
              g.res[n] = mk_res(8'h00, 1'b0, ERR_NONE, 1'b1, 1'b0);
              n++;
            end
          end
        endcase
        clear_decoder();
      end
    end
    if (n > 0) g.res[n-1].last_of_run = 1'b1;
    g.count = 2'(n);
    return g;
  endfunction

  // Called just after a rising edge; returns at the edge where the beat is taken.
  task automatic send_char(input logic [7:0] sym, input logic lst, input row_check_t check,
                           input b64d_result_t typed_res);
    b64d_group_t g;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      char_chan.valid  <= 1'b0;
      char_chan.symbol <= 8'($urandom_range(255));
      @(negedge clk);
    end
    char_chan.valid       <= 1'b1;
    char_chan.symbol      <= sym;
    char_chan.last_symbol <= lst;
    do @(posedge clk); while (!char_chan.ready);
    g = predict_decode(sym, lst);
    if (check == ROW_PREDICTED) begin
      for (int i = 0; i < int'(g.count); i++) expected_beats.push_back(g.res[i]);
    end else if (check == ROW_ONE_RESULT) begin
      expected_beats.push_back(typed_res);
    end
    chars_sent++;
    if (lst) messages_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    char_chan.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic send_message();
    int         kind;
    int         len;
    int         pads;
    int         bad_at;
    int         total;
    logic [7:0] ch;
    kind = $urandom_range(99);
    len  = $urandom_range(1, 14);
    pads = 0;
    if (len % 4 == 2) pads = $urandom_range(0, 2);
    if (len % 4 == 3) pads = $urandom_range(0, 1);
    if ($urandom_range(9) == 0) pads = $urandom_range(0, 4);
    total  = len + pads;
    bad_at = (kind >= 85) ? $urandom_range(0, total - 1) : -1;
    for (int i = 0; i < total; i++) begin
      if (kind >= 70 && kind < 85) ch = 8'($urandom_range(255));
      else if (i == bad_at && i >= len) ch = b64_chars[$urandom_range(63)];
      else if (i == bad_at) ch = 8'($urandom_range(255));
      else if (i < len) ch = b64_chars[$urandom_range(63)];
      else ch = CHAR_PAD;
      send_char(ch, i == total - 1, ROW_PREDICTED, '0);
    end
  endtask

  task automatic add_row(input logic [7:0] sym, input logic lst, input row_check_t check,
                         input b64d_result_t typed_res);
    stim_row_t row;
    row.sym       = sym;
    row.lst       = lst;
    row.check     = check;
    row.typed_res = typed_res;
    directed_rows.push_back(row);
  endtask

  task automatic flag_mismatch(input string what, input b64d_result_t exp_r,
                               input b64d_result_t act_r);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected byte=%02h valid=%0d err=%0d end=%0d last=%0d, got byte=%02h valid=%0d err=%0d end=%0d last=%0d",
               $realtime, what, exp_r.data_byte, exp_r.byte_valid, exp_r.error_code,
               exp_r.message_end, exp_r.last_of_run, act_r.data_byte, act_r.byte_valid,
               act_r.error_code, act_r.message_end, act_r.last_of_run);
    end
  endtask

  always @(posedge clk) begin
    b64d_result_t act_r;
    b64d_result_t exp_r;
    if (!rst && byte_chan.valid && byte_chan.ready) begin
      act_r.data_byte   = byte_chan.data_byte;
      act_r.byte_valid  = byte_chan.byte_valid;
      act_r.error_code  = b64d_err_t'(byte_chan.error_code);
      act_r.message_end = byte_chan.message_end;
      act_r.last_of_run = byte_chan.last_of_run;
      beats_checked++;
      if (act_r.byte_valid) bytes_seen++;
      if (act_r.error_code != ERR_NONE) errors_seen++;
      if (expected_beats.size() == 0) begin
        flag_mismatch("unexpected beat", '0, act_r);
      end else begin
        exp_r = expected_beats.pop_front();
        if (act_r.data_byte != exp_r.data_byte || act_r.byte_valid != exp_r.byte_valid ||
            act_r.error_code != exp_r.error_code || act_r.message_end != exp_r.message_end ||
            act_r.last_of_run != exp_r.last_of_run) begin
          flag_mismatch("wrong beat", exp_r, act_r);
        end
      end
    end
  end

  initial begin
    int hold_left;
    hold_left       = 0;
    byte_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        byte_chan.ready <= 1'b0;
      end else begin
        byte_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still outstanding.", expected_beats.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int phase_end;
    rst                   = 1'b1;
    char_chan.valid       = 1'b0;
    char_chan.symbol      = 8'h00;
    char_chan.last_symbol = 1'b0;
    src_idle_pct          = 0;
    sink_stall_pct        = 0;
    hold_request          = 0;
    mismatches            = 0;
    chars_sent            = 0;
    messages_sent         = 0;
    beats_checked         = 0;
    bytes_seen            = 0;
    errors_seen           = 0;
    clear_decoder();

    add_row(CHAR_PAD, 1'b1, ROW_ONE_RESULT, mk_res(8'h00, 1'b0, ERR_NONE, 1'b1, 1'b1));
    add_row(8'hFF, 1'b0, ROW_ONE_RESULT, mk_res(8'h00, 1'b0, ERR_NON_ASCII, 1'b0, 1'b1));
    add_row("A", 1'b0, ROW_NO_RESULT, '0);
    add_row(CHAR_PAD, 1'b1, ROW_ONE_RESULT, mk_res(8'h00, 1'b0, ERR_NON_ASCII, 1'b1, 1'b1));
    add_row(8'h80, 1'b1, ROW_ONE_RESULT, mk_res(8'h00, 1'b0, ERR_NON_ASCII, 1'b1, 1'b1));
    add_row(8'h7F, 1'b1, ROW_ONE_RESULT, mk_res(8'h00, 1'b0, ERR_ILLEGAL, 1'b1, 1'b1));
    add_row(8'h00, 1'b0, ROW_ONE_RESULT, mk_res(8'h00, 1'b0, ERR_ILLEGAL, 1'b0, 1'b1));
    add_row(8'h00, 1'b1, ROW_ONE_RESULT, mk_res(8'h00, 1'b0, ERR_ILLEGAL, 1'b1, 1'b1));
    add_row("/", 1'b1, ROW_ONE_RESULT, mk_res(8'h00, 1'b0, ERR_PREMATURE_END, 1'b1, 1'b1));
    add_row("/", 1'b0, ROW_PREDICTED, '0);
    add_row("/", 1'b0, ROW_PREDICTED, '0);
    add_row("/", 1'b0, ROW_PREDICTED, '0);
    add_row("/", 1'b1, ROW_PREDICTED, '0);
    for (int i = 0; i < 4; i++) add_row("A", 1'b0, ROW_PREDICTED, '0);
    add_row("+", 1'b0, ROW_PREDICTED, '0);
    add_row("9", 1'b0, ROW_PREDICTED, '0);
    add_row(CHAR_PAD, 1'b0, ROW_PREDICTED, '0);
    add_row(CHAR_PAD, 1'b1, ROW_PREDICTED, '0);
    add_row("Z", 1'b0, ROW_PREDICTED, '0);
    add_row("z", 1'b0, ROW_PREDICTED, '0);
    add_row("0", 1'b1, ROW_PREDICTED, '0);
    add_row(CHAR_PAD, 1'b0, ROW_NO_RESULT, '0);
    add_row("Q", 1'b1, ROW_ONE_RESULT, mk_res(8'h00, 1'b0, ERR_ILLEGAL, 1'b1, 1'b1));

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_char(directed_rows[i].sym, directed_rows[i].lst, directed_rows[i].check,
                directed_rows[i].typed_res);
    end
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      src_idle_pct   = (phase == 1 || phase == 3) ? ((phase == 1) ? 78 : 26) : 0;
      sink_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 78 : 26) : 0;
      phase_end      = chars_sent + 70;
      while (chars_sent < phase_end) send_message();
      wait_drained();
      if (phase == 0) begin
        hold_request = 40;
        for (int m = 0; m < 4; m++) send_message();
        wait_drained();
      end
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d characters in %0d messages over four pacing phases and a long output stall.",
             chars_sent, messages_sent);
    $display("Checked %0d result beats: %0d data bytes and %0d error reports.",
             beats_checked, bytes_seen, errors_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching beats in total.", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[base64_stream_decoder.f]
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_ifs.sv
hw/rtl/b64d_decode.sv
hw/rtl/b64d_out.sv
hw/rtl/base64_stream_decoder.sv
tb/base64_stream_decoder_tb.sv
